/* hdl/wcm_pkg.sv */
// Package for the word concatenation matcher: payload structs, codes,
// default sizes and the control structs shared by the cell modules.
// No dependencies.
package wcm_pkg;

    localparam int MAX_WORDS_DEF    = 8;
    localparam int MAX_WORD_LEN_DEF = 8;
    localparam int MAX_TEXT_LEN_DEF = 65536;

    localparam int CFG_W  = 4;
    localparam int WORD_W = 64;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEXT = 1'b1;

    // register indexes
    localparam logic REG_WORD_LEN   = 1'b0;
    localparam logic REG_WORD_COUNT = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [2:0]        word_slot;
        logic [WORD_W-1:0] word_value;
        logic [7:0]        text_char;
        logic              last_char;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [15:0] start_index;
        logic        end_of_string;
    } out_item_t;

    // control for the character window cells
    typedef struct packed {
        logic             shift_en;  // new character enters the window
        logic             scan_en;   // scan copy moves up by one word
        logic [CFG_W-1:0] len;       // word length in characters
    } char_ctrl_t;

    // control for the table slot cells
    typedef struct packed {
        logic clear_used;
        logic step;
    } slot_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

/* hdl/wcm_char_cell.sv */
// One byte of the character window: the live byte and its scan copy.
// Depends on wcm_pkg.
module wcm_char_cell
    import wcm_pkg::*;
#(
    parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  char_ctrl_t       ctrl,
    input  logic [7:0]       live_in,
    input  logic [7:0]       scan_in [MAX_WORD_LEN],
    output logic [7:0]       live_out,
    output logic [7:0]       scan_out
);

    logic [7:0] live_reg, live_next;
    logic [7:0] scan_reg, scan_next;
    logic [7:0] scan_tap;

    always_comb begin
        scan_tap = 8'h00;
        for (int j = 0; j < MAX_WORD_LEN; j++) begin
            if (ctrl.len == CFG_W'(j + 1)) begin
                scan_tap = scan_in[j];
            end
        end
    end

    always_comb begin
        live_next = live_reg;
        scan_next = scan_reg;
        if (ctrl.shift_en) begin
            // copy the shifted window so the scan starts from it
            live_next = live_in;
            scan_next = live_in;
        end else if (ctrl.scan_en) begin
            scan_next = scan_tap;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg <= 8'h00;
        end else begin
            live_reg <= live_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg <= scan_next;
    end

    assign live_out = live_reg;
    assign scan_out = scan_reg;

endmodule

/* hdl/wcm_slot_cell.sv */
// One table slot: stored word, used flag and the claim link of the slot chain.
// Depends on wcm_pkg.
module wcm_slot_cell
    import wcm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  slot_ctrl_t        ctrl,
    input  logic              load_en,
    input  logic [WORD_W-1:0] load_word,
    input  logic              enable,
    input  logic [WORD_W-1:0] mask,
    input  logic [WORD_W-1:0] probe,
    input  logic              taken_in,
    output logic              taken_out
);

    logic [WORD_W-1:0] word_reg;
    logic              used_reg, used_next;
    logic              hit;

    // claim only when no earlier slot took the word
    assign hit       = enable && !used_reg && ((word_reg & mask) == probe) && !taken_in;
    assign taken_out = taken_in || hit;

    always_comb begin
        used_next = used_reg;
        if (ctrl.clear_used) begin
            used_next = 1'b0;
        end else if (ctrl.step && hit) begin
            used_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
        end else begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            word_reg <= load_word;
        end
    end

endmodule

/* hdl/word_concatenation_matcher_core.sv */
// Top level of the word concatenation matcher: APB registers, control,
// the character window chain and the table slot chain.
// Depends on wcm_pkg, wcm_char_cell, wcm_slot_cell.
//
//  channel | ports                          | moves
//  --------+--------------------------------+---------------------------
//  input   | s_valid s_ready s_payload      | load or text word in
//  result  | m_valid m_ready m_payload      | match / end-of-string out
//  config  | psel penable pwrite paddr ...  | word_len, word_count
//
// A text word that needs no window check and is not the last character
// leaves the core idle; otherwise window words are scanned, one against all
// slots per cycle, until one finds no free matching slot or all match, and a
// match or a last character posts a result. Reset is synchronous and clears
// the window at once. s_ready is low while a word is scanned or its result
// waits for the output register; the output register holds until m_ready.
module word_concatenation_matcher_core
    import wcm_pkg::*;
#(
    parameter int MAX_WORDS    = MAX_WORDS_DEF,
    parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF,
    parameter int MAX_TEXT_LEN = MAX_TEXT_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_payload,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int WIN    = MAX_WORDS * MAX_WORD_LEN;
    localparam int PW     = $clog2(MAX_TEXT_LEN + 1);
    localparam int CNT_W  = $clog2(MAX_WORDS + 1);
    localparam int SPAN_W = $clog2(WIN + 1);

    // configuration
    logic [CFG_W-1:0] word_len_reg, word_count_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_len_reg   <= CFG_W'(1);
            word_count_reg <= CFG_W'(1);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_WORD_LEN) begin
                word_len_reg <= pwdata[CFG_W-1:0];
            end else begin
                word_count_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_WORD_LEN) begin
            prdata = {{(32 - CFG_W){1'b0}}, word_len_reg};
        end else begin
            prdata = {{(32 - CFG_W){1'b0}}, word_count_reg};
        end
    end

    logic [CFG_W-1:0]  len;
    logic [CNT_W-1:0]  cnt;
    logic [SPAN_W-1:0] span;

    assign len  = (int'(word_len_reg) > MAX_WORD_LEN) ? CFG_W'(MAX_WORD_LEN) : word_len_reg;
    assign cnt  = (int'(word_count_reg) > MAX_WORDS) ? CNT_W'(MAX_WORDS)
                                                     : CNT_W'(word_count_reg);
    assign span = SPAN_W'(SPAN_W'(len) * SPAN_W'(cnt));

    // control state
    state_t           state_reg, state_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             found_reg, found_next;
    logic             last_reg, last_next;
    logic [15:0]      start_reg, start_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_payload_reg, m_payload_next;

    logic          accept, text_acc, load_acc;
    logic          in_limit, check;
    logic [PW-1:0] pos_inc;
    logic [31:0]   start_full;
    logic          any_hit;
    logic          out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign text_acc = accept && (s_payload.operation == OP_TEXT);
    assign load_acc = accept && (s_payload.operation == OP_LOAD);

    assign in_limit   = 32'(pos_reg) < MAX_TEXT_LEN;
    assign pos_inc    = in_limit ? PW'(pos_reg + PW'(1)) : pos_reg;
    assign check      = in_limit && (span != '0) && (32'(pos_inc) >= 32'(span));
    assign start_full = 32'(pos_inc) - 32'(span);
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        found_next     = found_reg;
        last_next      = last_reg;
        start_next     = start_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        case (state_reg)
            ST_IDLE: begin
                if (text_acc) begin
                    pos_next   = s_payload.last_char ? '0 : pos_inc;
                    last_next  = s_payload.last_char;
                    start_next = start_full[15:0];
                    found_next = 1'b0;
                    k_next     = '0;
                    if (check) begin
                        state_next = ST_SCAN;
                    end else if (s_payload.last_char) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (any_hit && (k_reg == cnt - CNT_W'(1))) begin
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end else if (any_hit) begin
                    k_next = k_reg + CNT_W'(1);
                end else begin
                    // a window word that no free slot matches ends the scan
                    state_next = last_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next                 = 1'b1;
                    m_payload_next.found         = found_reg;
                    m_payload_next.start_index   = found_reg ? start_reg : 16'h0000;
                    m_payload_next.end_of_string = last_reg;
                    state_next                   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        found_reg     <= found_next;
        last_reg      <= last_next;
        start_reg     <= start_next;
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // character window chain, newest character at the top cell
    char_ctrl_t char_ctrl;
    logic [7:0] live [WIN];
    logic [7:0] scan [WIN];

    assign char_ctrl.shift_en = text_acc;
    assign char_ctrl.scan_en  = (state_reg == ST_SCAN);
    assign char_ctrl.len      = len;

    for (genvar i = 0; i < WIN; i++) begin : g_char
        logic [7:0] live_src;
        logic [7:0] scan_src [MAX_WORD_LEN];

        if (i == WIN - 1) begin : g_top
            assign live_src = s_payload.text_char;
        end else begin : g_mid
            assign live_src = live[i+1];
        end

        for (genvar j = 0; j < MAX_WORD_LEN; j++) begin : g_tap
            if (i - j - 1 >= 0) begin : g_in
                assign scan_src[j] = scan[i-j-1];
            end else begin : g_zero
                assign scan_src[j] = 8'h00;
            end
        end

        wcm_char_cell #(
            .MAX_WORD_LEN(MAX_WORD_LEN)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (char_ctrl),
            .live_in (live_src),
            .scan_in (scan_src),
            .live_out(live[i]),
            .scan_out(scan[i])
        );
    end

    // probe word from the top len cells of the scan copy, first byte low
    logic [WORD_W-1:0] probe;
    logic [WORD_W-1:0] mask;

    always_comb begin
        probe = '0;
        for (int l = 1; l <= MAX_WORD_LEN; l++) begin
            if (len == CFG_W'(l)) begin
                for (int b = 0; b < l; b++) begin
                    probe[8*b +: 8] = scan[WIN-l+b];
                end
            end
        end
    end

    always_comb begin
        for (int b = 0; b < WORD_W / 8; b++) begin
            mask[8*b +: 8] = (b < int'(len)) ? 8'hff : 8'h00;
        end
    end

    // table slot chain, the first free matching slot claims the word
    slot_ctrl_t slot_ctrl;
    logic       taken [MAX_WORDS+1];

    assign slot_ctrl.clear_used = text_acc;
    assign slot_ctrl.step       = (state_reg == ST_SCAN);
    assign taken[0]             = 1'b0;
    assign any_hit              = taken[MAX_WORDS];

    for (genvar t = 0; t < MAX_WORDS; t++) begin : g_slot
        logic load_en;
        logic enable;

        assign load_en = load_acc && (int'(s_payload.word_slot) == t);
        assign enable  = t < int'(cnt);

        wcm_slot_cell u_slot (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (slot_ctrl),
            .load_en  (load_en),
            .load_word(s_payload.word_value),
            .enable   (enable),
            .mask     (mask),
            .probe    (probe),
            .taken_in (taken[t]),
            .taken_out(taken[t+1])
        );
    end

endmodule

/* tb/wcm_report_checker.sv */
`timescale 1ns / 1ps
// Checker for word_concatenation_matcher_core: tracks register writes and accepted
// input words, predicts the match and end-of-string reports, compares result words.
// Depends on wcm_pkg.
module wcm_report_checker
    import wcm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_item_t    s_payload,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_item_t   m_payload,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          reports_due,
    output int          reports_seen,
    output int          hits_seen
);

    localparam int WIN_BYTES = MAX_WORDS_DEF * MAX_WORD_LEN_DEF;
    localparam int TEXT_CAP  = MAX_TEXT_LEN_DEF;

    logic [7:0]        text_window [WIN_BYTES];
    logic [WORD_W-1:0] word_table  [MAX_WORDS_DEF];
    logic [16:0]       char_pos;
    logic [CFG_W-1:0]  cfg_len;
    logic [CFG_W-1:0]  cfg_count;
    out_item_t         report_fifo [$];

    // Split the newest len*cnt characters into cnt words and match them as a
    // multiset against table slots 0..cnt-1.
    function automatic bit window_is_concatenation(int len, int cnt);
        bit                used [MAX_WORDS_DEF];
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] piece;
        int                base;
        bit                hit;
        mask = (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
        base = WIN_BYTES - len * cnt;
        foreach (used[t]) used[t] = 1'b0;
        for (int k = 0; k < cnt; k++) begin
            piece = '0;
            for (int b = 0; b < len; b++) begin
                piece[8*b +: 8] = text_window[base + k * len + b];
            end
            hit = 1'b0;
            for (int t = 0; t < cnt; t++) begin
                if (!hit && !used[t] && (word_table[t] & mask) == piece) begin
                    used[t] = 1'b1;
                    hit     = 1'b1;
                end
            end
            if (!hit) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic take_word(input in_item_t w);
        int        len;
        int        cnt;
        int        span;
        bit        in_range;
        bit        hit;
        out_item_t r;
        if (w.operation == OP_LOAD) begin
            word_table[w.word_slot] = w.word_value;
            return;
        end
        for (int i = 0; i < WIN_BYTES - 1; i++) text_window[i] = text_window[i+1];
        text_window[WIN_BYTES-1] = w.text_char;
        in_range = char_pos < TEXT_CAP;
        if (in_range) char_pos++;
        len  = (cfg_len > MAX_WORD_LEN_DEF) ? MAX_WORD_LEN_DEF : cfg_len;
        cnt  = (cfg_count > MAX_WORDS_DEF) ? MAX_WORDS_DEF : cfg_count;
        span = len * cnt;
        hit  = 1'b0;
        if (in_range && span != 0 && char_pos >= span) hit = window_is_concatenation(len, cnt);
        r.found         = hit;
        r.start_index   = hit ? 16'(char_pos - span) : 16'd0;
        r.end_of_string = w.last_char;
        if (w.last_char) char_pos = '0;
        if (hit || w.last_char) report_fifo.insert(report_fifo.size(), r);
    endtask

    always @(posedge aclk) begin : watch
        out_item_t want;
        if (!aresetn) begin
            foreach (text_window[i]) text_window[i] = '0;
            foreach (word_table[i]) word_table[i] = '0;
            char_pos  = '0;
            cfg_len   = 4'd1;
            cfg_count = 4'd1;
            report_fifo.delete();
        end else begin
            // compare first: a report never belongs to a word taken at the same edge
            if (m_valid && m_ready) begin
                reports_seen++;
                if (m_payload.found) hits_seen++;
                if (report_fifo.size() == 0) begin
                    fail_count++;
                    $error("unexpected result word: found %0d start_index %0d end_of_string %0d",
                           m_payload.found, m_payload.start_index, m_payload.end_of_string);
                end else begin
                    want = report_fifo.pop_front();
                    if (m_payload.found !== want.found) begin
                        fail_count++;
                        $error("found: expected %0d, got %0d", want.found, m_payload.found);
                    end
                    if (m_payload.start_index !== want.start_index) begin
                        fail_count++;
                        $error("start_index: expected %0d, got %0d",
                               want.start_index, m_payload.start_index);
                    end
                    if (m_payload.end_of_string !== want.end_of_string) begin
                        fail_count++;
                        $error("end_of_string: expected %0d, got %0d",
                               want.end_of_string, m_payload.end_of_string);
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr == {REG_WORD_LEN, 2'b00}) begin
                    cfg_len = pwdata[CFG_W-1:0];
                end else if (paddr == {REG_WORD_COUNT, 2'b00}) begin
                    cfg_count = pwdata[CFG_W-1:0];
                end
            end
            if (s_valid && s_ready) take_word(s_payload);
        end
        reports_due = report_fifo.size();
    end

endmodule

/* tb/word_concatenation_matcher_core_test.sv */
`timescale 1ns / 1ps
// Testbench top for word_concatenation_matcher_core: clock, reset, register and
// input stimulus, result back-pressure and the verdict.
// Depends on wcm_pkg, word_concatenation_matcher_core and wcm_report_checker.
module word_concatenation_matcher_core_test;
    import wcm_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = MAX_WORDS_DEF + 4;
    localparam int PHASE_WORDS  = 105;
    localparam logic [7:0] CH_A = 8'h61;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_payload = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_payload;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int reports_due;
    int reports_seen;
    int hits_seen;
    int cycle_count = 0;
    int words_sent  = 0;
    int rx_hold     = 0;
    bit tx_idle     = 1'b1;
    bit rx_idle     = 1'b1;

    // stimulus-side copy of the table, used to build matching strings
    logic [63:0] loaded [MAX_WORDS_DEF];

    word_concatenation_matcher_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    wcm_report_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .fail_count(fail_count), .reports_due(reports_due),
        .reports_seen(reports_seen), .hits_seen(hits_seen)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("word_concatenation_matcher_core_test NOT OK");
            $finish;
        end
    end

    // result side: drop m_ready in bursts of random length while enabled
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else if (rx_idle && $urandom_range(0, 9) == 0) begin
            rx_hold = $urandom_range(0, 12);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_word(input in_item_t w);
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic load_word(input logic [2:0] slot, input logic [63:0] value);
        in_item_t w;
        w.operation  = OP_LOAD;
        w.word_slot  = slot;
        w.word_value = value;
        w.text_char  = 8'($urandom);
        w.last_char  = 1'($urandom);
        loaded[slot] = value;
        send_word(w);
    endtask

    task automatic text_word(input logic [7:0] ch, input bit last);
        in_item_t w;
        w.operation  = OP_TEXT;
        w.word_slot  = 3'($urandom);
        w.word_value = {$urandom, $urandom};
        w.text_char  = ch;
        w.last_char  = last;
        send_word(w);
    endtask

    // hold off until every report is in, then let a scan with no report finish
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (reports_due != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic reg_index, input logic [3:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= {28'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_sizes(input logic [3:0] len, input logic [3:0] count);
        settle();
        write_reg(REG_WORD_LEN, len);
        write_reg(REG_WORD_COUNT, count);
    endtask

    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 19) == 0) return 8'($urandom);
        return CH_A + 8'($urandom_range(0, 2));
    endfunction

    // words drawn from two letters give plenty of duplicates; high bytes sometimes junk
    function automatic logic [63:0] make_table_word(int len);
        logic [63:0] v;
        v = ($urandom_range(0, 2) == 0) ? {$urandom, $urandom} : 64'd0;
        for (int b = 0; b < len && b < 8; b++) v[8*b +: 8] = CH_A + 8'($urandom_range(0, 1));
        return v;
    endfunction

    task automatic run_phase(input logic [3:0] len_reg, input logic [3:0] count_reg,
                             input bit idle_on);
        logic [7:0]  chars [$];
        int          order [MAX_WORDS_DEF];
        int          len;
        int          cnt;
        int          span;
        int          target;
        int          sel;
        int          nseg;
        int          j;
        int          tmp;
        int          done;
        logic [2:0]  slot;
        logic [63:0] v;
        set_sizes(len_reg, count_reg);
        tx_idle = idle_on;
        rx_idle = idle_on;
        len  = (len_reg > MAX_WORD_LEN_DEF) ? MAX_WORD_LEN_DEF : len_reg;
        cnt  = (count_reg > MAX_WORDS_DEF) ? MAX_WORDS_DEF : count_reg;
        span = len * cnt;
        done = 0;
        for (int s = 0; s < MAX_WORDS_DEF; s++) begin
            if ($urandom_range(0, 1) == 0) begin
                load_word(3'(s), make_table_word(len));
                done++;
            end
        end
        while (done < PHASE_WORDS) begin
            chars.delete();
            target = $urandom_range(1, 3 * span + 8);
            while (chars.size() < target) begin
                sel = $urandom_range(0, 9);
                if (span != 0 && sel < 7) begin
                    // a permutation of the active words, or one random table word
                    nseg = (sel < 5) ? cnt : 1;
                    for (int i = 0; i < cnt; i++) order[i] = i;
                    for (int i = cnt - 1; i > 0; i--) begin
                        j        = $urandom_range(0, i);
                        tmp      = order[i];
                        order[i] = order[j];
                        order[j] = tmp;
                    end
                    if (nseg == 1) order[0] = $urandom_range(0, MAX_WORDS_DEF - 1);
                    for (int k = 0; k < nseg; k++) begin
                        for (int b = 0; b < len; b++) begin
                            chars.insert(chars.size(), loaded[order[k]][8*b +: 8]);
                        end
                    end
                end else begin
                    repeat ($urandom_range(1, 3)) chars.insert(chars.size(), pick_char());
                end
            end
            for (int i = 0; i < chars.size(); i++) begin
                if ($urandom_range(0, 39) == 0) begin
                    slot = 3'($urandom_range(0, MAX_WORDS_DEF - 1));
                    v    = make_table_word(len);
                    load_word(slot, v);
                    done++;
                end
                text_word(chars[i], i == chars.size() - 1);
                done++;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: two-character words "ab" and "cd"
        set_sizes(4'd2, 4'd2);
        load_word(3'd0, 64'hffff_ffff_ffff_6261);
        load_word(3'd1, 64'h0000_0000_0000_6463);
        for (int s = 2; s < MAX_WORDS_DEF - 1; s++) load_word(3'(s), make_table_word(2));
        load_word(3'd7, '1);
        text_word(8'h63, 1'b0);
        text_word(8'h64, 1'b0);
        text_word(8'h61, 1'b0);
        text_word(8'h62, 1'b1);
        text_word(8'h00, 1'b0);
        text_word(8'hff, 1'b1);
        text_word(8'h61, 1'b0);
        text_word(8'h62, 1'b0);
        text_word(8'h63, 1'b0);
        text_word(8'h64, 1'b0);
        text_word(8'h78, 1'b1);

        run_phase(4'd3,  4'd2,  1'b1);
        run_phase(4'd1,  4'd1,  1'b1);
        run_phase(4'd8,  4'd8,  1'b1);
        run_phase(4'd0,  4'd3,  1'b1);
        run_phase(4'd2,  4'd0,  1'b1);
        run_phase(4'd15, 4'd15, 1'b1);
        run_phase(4'd4,  4'd3,  1'b0);
        run_phase(4'd1,  4'd8,  1'b1);
        run_phase(4'd15, 4'd2,  1'b1);
        run_phase(4'd5,  4'd1,  1'b0);
        run_phase(4'd2,  4'd5,  1'b0);
        settle();

        $display("Sent %0d input words over 12 word size settings, last stretch without stalls.",
                 words_sent);
        $display("Checked %0d result words, %0d of them matches.", reports_seen, hits_seen);
        if (fail_count == 0) begin
            $display("word_concatenation_matcher_core_test OK");
        end else begin
            $display("word_concatenation_matcher_core_test NOT OK");
        end
        $finish;
    end

endmodule
